[rtl/ptw_pkg.sv]
package ptw_pkg;

    // Operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_XLATE  = 2'd1;
    localparam logic [1:0] OP_MAP    = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_COARSE = 2'd1;
    localparam logic [1:0] ST_NOT_SMALL  = 2'd2;
    localparam logic [1:0] ST_UNMAPPED   = 2'd3;

    // First-level descriptor types
    localparam logic [1:0] DT_FAULT   = 2'd0;
    localparam logic [1:0] DT_COARSE  = 2'd1;
    localparam logic [1:0] DT_SECTION = 2'd2;
    localparam logic [1:0] DT_FINE    = 2'd3;

    // Second-level small page type
    localparam logic [1:0] PT_SMALL = 2'd2;

    localparam logic [31:0] TABLE_BASE_RST = 32'h0020_0000;
    localparam logic [31:0] PAGE_STEP      = 32'h0000_1000;

    // Walker sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_L1   = 4'b0010,
        S_L1D  = 4'b0100,
        S_L2D  = 4'b1000
    } t_state;

    // First-level descriptor byte address
    function automatic logic [31:0] l1_byte_addr(input logic [31:0] base,
                                                 input logic [31:0] va);
        return {base[31:14], va[31:20], 2'b00};
    endfunction

endpackage

[rtl/ptw_ram.sv]
module ptw_ram #(
    parameter int WIDTH      = 32,
    parameter int DEPTH_LOG2 = 16
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [DEPTH_LOG2-1:0] i_waddr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic [DEPTH_LOG2-1:0] i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);

    logic [WIDTH-1:0] r_mem [0:(1 << DEPTH_LOG2)-1];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/page_table_walk_and_update.sv]
// Channel   Direction  Handshake                       Payload
// --------  ---------  ------------------------------  -----------------------------------
// command   in         start high while busy low       i_operation, i_virt_addr, i_phys_addr,
//                                                      i_page_count, i_access_perm,
//                                                      i_word_index, i_word_data
// result    out        o_strobe, one cycle, no stall   o_result_addr, o_status
// config    in         i_cfg_valid & o_cfg_ready       i_table_base
//
// Load, undefined operations and a zero-length map finish at acceptance; the result
// strobes on the next cycle. Translate ends after the first-level read for a section or
// fault; page tables take a second read that depends on the first, both on the single
// table RAM read port. Map handles each page in turn (read descriptor, read entry, write
// entry back); the first descriptor read is issued in the acceptance cycle.
// The result strobes in the cycle after the last step; busy is already low then.
// Reset is synchronous, active low; table RAM contents are not cleared.
module page_table_walk_and_update #(
    parameter int MEM_WORDS_LOG2 = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_virt_addr,
    input  logic [31:0] i_phys_addr,
    input  logic [9:0]  i_page_count,
    input  logic [1:0]  i_access_perm,
    input  logic [15:0] i_word_index,
    input  logic [31:0] i_word_data,
    output logic        o_strobe,
    output logic [31:0] o_result_addr,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_table_base
);
    import ptw_pkg::*;

    localparam int AW = MEM_WORDS_LOG2;

    t_state        r_state, n_state;
    logic          r_map, n_map;
    logic          r_fine, n_fine;
    logic [31:0]   r_va, n_va;
    logic [31:0]   r_pa, n_pa;
    logic [9:0]    r_cnt, n_cnt;
    logic [1:0]    r_ap, n_ap;
    logic [AW-1:0] r_ea, n_ea;
    logic [31:0]   r_table_base;
    logic          r_strobe, n_strobe;
    logic [31:0]   r_result_addr, n_result_addr;
    logic [1:0]    r_status, n_status;

    logic          w_accept;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wdata;
    logic [AW-1:0] w_raddr;
    logic [31:0]   w_rdata;
    logic [31:0]   w_rd_byte;
    logic [31:0]   w_widx_ext;

    assign w_accept    = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    // Base changes only with no item in flight or being accepted
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign w_widx_ext  = {16'b0, i_word_index};

    // Read address: first level from the command or the run, second level from data, else from the physical address
    always_comb begin
        unique case (r_state)
            S_IDLE: w_rd_byte = l1_byte_addr(r_table_base, i_virt_addr);
            S_L1:   w_rd_byte = l1_byte_addr(r_table_base, r_va);
            S_L1D: begin
                if (!r_map && (w_rdata[1:0] == DT_FINE)) begin
                    w_rd_byte = {w_rdata[31:12], r_va[19:10], 2'b00};
                end else begin
                    w_rd_byte = {w_rdata[31:10], r_va[19:12], 2'b00};
                end
            end
            default: w_rd_byte = {r_pa[31:2], 2'b00};
        endcase
    end
    assign w_raddr = w_rd_byte[AW+1:2];

    // Sequencer and result formation
    always_comb begin
        n_state       = r_state;
        n_map         = r_map;
        n_fine        = r_fine;
        n_va          = r_va;
        n_pa          = r_pa;
        n_cnt         = r_cnt;
        n_ap          = r_ap;
        n_ea          = r_ea;
        n_strobe      = 1'b0;
        n_result_addr = r_result_addr;
        n_status      = r_status;
        w_we          = 1'b0;
        w_waddr       = r_ea;
        w_wdata       = {r_pa[31:12], r_ap, r_ap, r_ap, r_ap, w_rdata[3:0]};

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_va          = i_virt_addr;
                    n_pa          = i_phys_addr;
                    n_cnt         = i_page_count;
                    n_ap          = i_access_perm;
                    n_result_addr = '0;
                    n_status      = ST_OK;
                    unique case (i_operation)
                        OP_LOAD: begin
                            w_we     = 1'b1;
                            w_waddr  = w_widx_ext[AW-1:0];
                            w_wdata  = i_word_data;
                            n_strobe = 1'b1;
                        end
                        OP_XLATE: begin
                            n_map   = 1'b0;
                            n_state = S_L1D;
                        end
                        OP_MAP: begin
                            n_map = 1'b1;
                            if (i_page_count == '0) begin
                                n_strobe = 1'b1;
                            end else begin
                                n_state = S_L1D;
                            end
                        end
                        default: n_strobe = 1'b1;
                    endcase
                end
            end
            S_L1: begin
                n_state = S_L1D;
            end
            S_L1D: begin
                n_ea   = w_raddr;
                n_fine = (w_rdata[1:0] == DT_FINE);
                if (r_map) begin
                    if (w_rdata[1:0] != DT_COARSE) begin
                        n_strobe = 1'b1;
                        n_status = ST_NOT_COARSE;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_L2D;
                    end
                end else begin
                    case (w_rdata[1:0])
                        DT_SECTION: begin
                            n_strobe      = 1'b1;
                            n_result_addr = {w_rdata[31:20], r_va[19:0]};
                            n_state       = S_IDLE;
                        end
                        DT_FAULT: begin
                            n_strobe = 1'b1;
                            n_status = ST_UNMAPPED;
                            n_state  = S_IDLE;
                        end
                        default: n_state = S_L2D;
                    endcase
                end
            end
            S_L2D: begin
                if (!r_map) begin
                    n_strobe      = 1'b1;
                    n_result_addr = r_fine ? {w_rdata[31:10], r_va[9:0]}
                                           : {w_rdata[31:12], r_va[11:0]};
                    n_state       = S_IDLE;
                end else if (w_rdata[1:0] != PT_SMALL) begin
                    n_strobe = 1'b1;
                    n_status = ST_NOT_SMALL;
                    n_state  = S_IDLE;
                end else begin
                    // Update the small-page entry, then step to the next page or finish on the last
                    w_we = 1'b1;
                    if (r_cnt == 10'd1) begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt - 10'd1;
                        n_va    = r_va + PAGE_STEP;
                        n_pa    = r_pa + PAGE_STEP;
                        n_state = S_L1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_strobe     <= 1'b0;
            r_table_base <= TABLE_BASE_RST;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_table_base <= i_table_base;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_map         <= n_map;
        r_fine        <= n_fine;
        r_va          <= n_va;
        r_pa          <= n_pa;
        r_cnt         <= n_cnt;
        r_ap          <= n_ap;
        r_ea          <= n_ea;
        r_result_addr <= n_result_addr;
        r_status      <= n_status;
    end

    ptw_ram #(
        .WIDTH      (32),
        .DEPTH_LOG2 (AW)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_strobe      = r_strobe;
    assign o_result_addr = r_result_addr;
    assign o_status      = r_status;

    // A result is only ever shown once the walker is back in idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == S_IDLE))
        else $error("result strobe while walker busy");

    // Table writes come only from a load at acceptance or an entry update
    a_we_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == S_IDLE) || (r_state == S_L2D)))
        else $error("table write outside load or update step");

    // Every accepted item either finishes at once or keeps the walker busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_strobe || busy))
        else $error("accepted item dropped");

    // A translate second-level read always completes on the next cycle
    a_xlate_l2_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_L2D) && !r_map) |=> r_strobe)
        else $error("translate did not complete after second-level read");

    // Map results carry a zero address, whatever their status
    a_map_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_map) |-> (r_result_addr == '0))
        else $error("map result with nonzero address");

endmodule
